// File: hdl/hsc_pkg.sv
// hsc_pkg: shared widths, action codes, request/response types and the
// position helpers of the Hamming single-error-correcting codec.
// No dependencies; every other file of the codec depends on it.
`default_nettype none

package hsc_pkg;

    // Fixed field widths
    localparam int WORD_W = 63;
    localparam int LEN_W  = 6;
    localparam int SYN_W  = 6;
    localparam int K_W    = 6;

    // Defaults for the top-level parameter and the data_bits register
    localparam int MAX_DATA_BITS_DEF = 57;
    localparam logic [K_W-1:0] DATA_BITS_RESET = 6'd4;

    // Action codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // Codeword geometry held by the configuration block
    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [LEN_W-1:0] len;
    } t_cfg;

    // Result of one request
    typedef struct packed {
        t_word            result_word;
        logic [LEN_W-1:0] result_length;
        logic [SYN_W-1:0] syndrome;
        logic             corrected;
        logic             bad_syndrome;
    } t_rsp;

    // Position (1-based) of the j-th data bit: the j-th non-power-of-two position
    function automatic int data_pos(input int j);
        int pos;
        int placed;
        pos    = 0;
        placed = 0;
        for (int p = 1; p <= WORD_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (placed == j) begin
                    pos = p;
                end
                placed++;
            end
        end
        return pos;
    endfunction

    // Clamp a written data_bits value into 1..max_k
    function automatic logic [K_W-1:0] clamp_k(input logic [K_W-1:0] v, input int max_k);
        logic [K_W-1:0] k;
        k = v;
        if (k == '0) begin
            k = K_W'(1);
        end
        if (k > K_W'(max_k)) begin
            k = K_W'(max_k);
        end
        return k;
    endfunction

    // Codeword length for k data bits: k plus the smallest check count r
    // with 2**r >= k + r + 1
    function automatic logic [LEN_W-1:0] code_len(input logic [K_W-1:0] k);
        logic [LEN_W-1:0] r;
        logic             found;
        r     = '0;
        found = 1'b0;
        for (int i = 0; i <= SYN_W; i++) begin
            if (!found && ((8'd1 << i) >= (8'(k) + 8'(i) + 8'd1))) begin
                r     = LEN_W'(i);
                found = 1'b1;
            end
        end
        return LEN_W'(k) + r;
    endfunction

    // XOR of the positions of all set bits
    function automatic logic [SYN_W-1:0] syn_of(input t_word v);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                s = s ^ SYN_W'(i + 1);
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hsc_intf.sv
// hsc_req_if / hsc_rsp_if: valid/ready channels of the codec.
// Depend on hsc_pkg for the field widths.
`default_nettype none

interface hsc_req_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    hsc_pkg::t_word       word;

    modport source (output valid, output action, output word, input ready);
    modport sink   (input valid, input action, input word, output ready);
endinterface

interface hsc_rsp_if;
    logic                          valid;
    logic                          ready;
    hsc_pkg::t_word                result_word;
    logic [hsc_pkg::LEN_W-1:0]     result_length;
    logic [hsc_pkg::SYN_W-1:0]     syndrome;
    logic                          corrected;
    logic                          bad_syndrome;

    modport source (output valid, output result_word, output result_length,
                    output syndrome, output corrected, output bad_syndrome, input ready);
    modport sink   (input valid, input result_word, input result_length,
                    input syndrome, input corrected, input bad_syndrome, output ready);
endinterface

`default_nettype wire

// File: hdl/hamming_sec_codec_core.sv
// hamming_sec_codec_core: Hamming SEC codec top level, input register,
// combinational codec and result register. Depends on hsc_pkg, hsc_intf,
// hsc_cfg and hsc_xcode.
//
//   channel   dir  handshake          payload
//   i_req     in   valid/ready        action, word
//   o_rsp     out  valid/ready        result_word, result_length, syndrome,
//                                     corrected, bad_syndrome
//   i_cfg_*   in   write enable only  data_bits (6 bits)
//
// The response is valid after the request has passed the input register and then the
// result register; one request per cycle is sustained while o_rsp is not stalled, with
// the combinational XOR trees between the two registers.
// Reset (synchronous, active low) empties both stages and loads data_bits = 4.
// A stalled response holds in the result register; the input register still
// takes a request while it is empty or moving forward.
`default_nettype none

module hamming_sec_codec_core #(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    hsc_req_if.sink                      i_req,
    hsc_rsp_if.source                    o_rsp,
    input  wire logic                    i_cfg_we,
    input  wire logic [hsc_pkg::K_W-1:0] i_cfg_wdata
);
    import hsc_pkg::*;

    t_cfg  cfg;
    t_rsp  xc_rsp;

    logic  r_s1_valid;
    logic  r_s1_action;
    t_word r_s1_word;
    logic  r_out_valid;
    t_rsp  r_out;

    logic  s1_ready;
    logic  out_ready;
    logic  n_s1_valid;
    logic  n_out_valid;

    hsc_cfg #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    hsc_xcode #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_xcode (
        .i_action (r_s1_action),
        .i_word   (r_s1_word),
        .i_cfg    (cfg),
        .o_rsp    (xc_rsp)
    );

    // Advance when the next stage is empty or draining
    assign out_ready   = !r_out_valid || o_rsp.ready;
    assign s1_ready    = !r_s1_valid || out_ready;
    assign n_s1_valid  = s1_ready ? i_req.valid : r_s1_valid;
    assign n_out_valid = out_ready ? r_s1_valid : r_out_valid;

    // Hold valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_action <= i_req.action;
            r_s1_word   <= i_req.word;
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out <= xc_rsp;
        end
    end

    assign i_req.ready         = s1_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.result_word   = r_out.result_word;
    assign o_rsp.result_length = r_out.result_length;
    assign o_rsp.syndrome      = r_out.syndrome;
    assign o_rsp.corrected     = r_out.corrected;
    assign o_rsp.bad_syndrome  = r_out.bad_syndrome;

endmodule

`default_nettype wire

// File: hdl/hsc_cfg.sv
// hsc_cfg: data_bits register, clamped on write, with the derived codeword length.
// Depends on hsc_pkg.
`default_nettype none

module hsc_cfg #(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [hsc_pkg::K_W-1:0] i_cfg_wdata,
    output hsc_pkg::t_cfg                o_cfg
);
    import hsc_pkg::*;

    localparam logic [K_W-1:0]   RST_K   = clamp_k(DATA_BITS_RESET, MAX_DATA_BITS);
    localparam logic [LEN_W-1:0] RST_LEN = code_len(RST_K);

    t_cfg           r_cfg;
    logic [K_W-1:0] n_k;

    // Clamp the written value once, here
    assign n_k = clamp_k(i_cfg_wdata, MAX_DATA_BITS);

    // Hold geometry; update on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k   <= RST_K;
            r_cfg.len <= RST_LEN;
        end else if (i_cfg_we) begin
            r_cfg.k   <= n_k;
            r_cfg.len <= code_len(n_k);
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hdl/hsc_xcode.sv
// hsc_xcode: combinational encode / syndrome-correct-strip logic for one request.
// Depends on hsc_pkg.
`default_nettype none

module hsc_xcode #(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEF
) (
    input  wire logic           i_action,
    input  wire hsc_pkg::t_word i_word,
    input  wire hsc_pkg::t_cfg  i_cfg,
    output hsc_pkg::t_rsp       o_rsp
);
    import hsc_pkg::*;

    t_word            enc_data;
    t_word            enc_cw;
    logic [SYN_W-1:0] enc_syn;
    t_word            dec_cw;
    t_word            dec_fixed;
    t_word            dec_data;
    logic [SYN_W-1:0] dec_syn;
    logic             dec_fix;
    logic             dec_bad;

    // Encode: spread data bits over non-power-of-two positions
    always_comb begin
        enc_data = '0;
        for (int j = 0; j < MAX_DATA_BITS; j++) begin
            enc_data[data_pos(j) - 1] = i_word[j] & (K_W'(j) < i_cfg.k);
        end
    end

    assign enc_syn = syn_of(enc_data);

    // Encode: check bit 2**i takes syndrome bit i
    always_comb begin
        enc_cw = enc_data;
        for (int i = 0; i < SYN_W; i++) begin
            enc_cw[(1 << i) - 1] = enc_syn[i];
        end
    end

    // Decode: drop bits beyond the codeword, then form the syndrome
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            dec_cw[i] = i_word[i] & (LEN_W'(i) < i_cfg.len);
        end
    end

    assign dec_syn = syn_of(dec_cw);
    assign dec_fix = (dec_syn != '0) && (dec_syn <= i_cfg.len);
    assign dec_bad = (dec_syn != '0) && (dec_syn > i_cfg.len);

    // Decode: flip the addressed bit, then strip check bits
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            dec_fixed[i] = dec_cw[i] ^ (dec_fix && (dec_syn == SYN_W'(i + 1)));
        end
        dec_data = '0;
        for (int j = 0; j < MAX_DATA_BITS; j++) begin
            dec_data[j] = dec_fixed[data_pos(j) - 1] & (K_W'(j) < i_cfg.k);
        end
    end

    // Select the result for the requested action
    always_comb begin
        if (i_action == ACT_DECODE) begin
            o_rsp.result_word   = dec_data;
            o_rsp.result_length = LEN_W'(i_cfg.k);
            o_rsp.syndrome      = dec_syn;
            o_rsp.corrected     = dec_fix;
            o_rsp.bad_syndrome  = dec_bad;
        end else begin
            o_rsp.result_word   = enc_cw;
            o_rsp.result_length = i_cfg.len;
            o_rsp.syndrome      = '0;
            o_rsp.corrected     = 1'b0;
            o_rsp.bad_syndrome  = 1'b0;
        end
    end

endmodule

`default_nettype wire
